// ----- src/gpbt_pkg.sv -----
// Shared types, codes and the neighbor offset table for the grid path backtrace step core.
package gpbt_pkg;

   // Input item operation codes.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   // Configuration register indexes.
   localparam logic REG_GRID_ROWS = 1'b0;
   localparam logic REG_GRID_COLS = 1'b1;

   // Fixed field widths of the item interface.
   localparam int CFG_W     = 7;
   localparam int COORD_W   = 6;
   localparam int COST_IN_W = 16;

   // Working width for neighbor coordinates and bounds (covers 1024 plus one).
   localparam int WIDE_W = 11;

   // Scan slots: the queried cell first, then the eight neighbors in search order.
   localparam int SCAN_W = 4;
   localparam logic [SCAN_W-1:0] SCAN_HERE       = 4'd0;
   localparam logic [SCAN_W-1:0] SCAN_UP         = 4'd1;
   localparam logic [SCAN_W-1:0] SCAN_LEFT       = 4'd2;
   localparam logic [SCAN_W-1:0] SCAN_DOWN       = 4'd3;
   localparam logic [SCAN_W-1:0] SCAN_RIGHT      = 4'd4;
   localparam logic [SCAN_W-1:0] SCAN_UP_LEFT    = 4'd5;
   localparam logic [SCAN_W-1:0] SCAN_DOWN_LEFT  = 4'd6;
   localparam logic [SCAN_W-1:0] SCAN_DOWN_RIGHT = 4'd7;
   localparam logic [SCAN_W-1:0] SCAN_UP_RIGHT   = 4'd8;
   localparam logic [SCAN_W-1:0] SCAN_LAST       = SCAN_UP_RIGHT;

   // Step controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } gpbt_state_type;

   // Direction of one scan slot relative to the queried cell.
   typedef struct packed {
      logic row_dec;
      logic row_inc;
      logic col_dec;
      logic col_inc;
   } gpbt_offset_type;

   // Maps a scan slot to its row and column step.
   function automatic gpbt_offset_type nbr_offset(input logic [SCAN_W-1:0] slot);
      gpbt_offset_type off;
      off = '0;
      case (slot)
         SCAN_UP:         off.row_dec = 1'b1;
         SCAN_LEFT:       off.col_dec = 1'b1;
         SCAN_DOWN:       off.row_inc = 1'b1;
         SCAN_RIGHT:      off.col_inc = 1'b1;
         SCAN_UP_LEFT:    begin
            off.row_dec = 1'b1;
            off.col_dec = 1'b1;
         end
         SCAN_DOWN_LEFT:  begin
            off.row_inc = 1'b1;
            off.col_dec = 1'b1;
         end
         SCAN_DOWN_RIGHT: begin
            off.row_inc = 1'b1;
            off.col_inc = 1'b1;
         end
         SCAN_UP_RIGHT:   begin
            off.row_dec = 1'b1;
            off.col_inc = 1'b1;
         end
         default:         off = '0;
      endcase
      return off;
   endfunction

endpackage

// ----- src/gpbt_grid_ram.sv -----
// Single-port-per-side grid cell memory with a registered read.
module gpbt_grid_ram #(
   parameter int ADDR_W = 12,
   parameter int DATA_W = 17
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port with a registered output.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/grid_path_backtrace_step_core.sv -----
// Top level of the grid path backtrace step core: cell loading and one descent step.
//
// The block keeps a cost grid (a path cost and an occupied mark per cell) in one
// on-chip memory. A write item stores one cell and answers in the next cycle. A
// step item reads the queried cell and its eight neighbors from that memory, one
// read per cycle, and returns the free in-bounds neighbor with the lowest cost
// below the queried cell (first found wins on a tie), or flags the start (cost
// zero) or stuck. A step inside the configured grid is accepted, then makes nine
// memory reads through the registered read port, then loads the result register
// once the result slot is free; the single read port of the grid memory sets the
// pace of the reads. A step outside the configured grid skips the reads. A step
// item may be accepted while an earlier result still waits to be taken; a write
// item waits for a free result slot. Cells must be written before they are read:
// the memory is not cleared after reset. grid_rows and grid_cols may only be
// written while the block is idle.
module grid_path_backtrace_step_core #(
   parameter int MAX_ROWS  = 64,
   parameter int MAX_COLS  = 64,
   parameter int COST_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_op,
   input  logic [gpbt_pkg::COORD_W-1:0]  req_cell_row,
   input  logic [gpbt_pkg::COORD_W-1:0]  req_cell_col,
   input  logic [gpbt_pkg::COST_IN_W-1:0] req_cell_cost,
   input  logic                          req_cell_blocked,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [gpbt_pkg::COORD_W-1:0]  rsp_next_row,
   output logic [gpbt_pkg::COORD_W-1:0]  rsp_next_col,
   output logic                          rsp_at_start,
   output logic                          rsp_stuck,
   input  logic                          csr_wr_en,
   input  logic                          csr_index,
   input  logic [gpbt_pkg::CFG_W-1:0]    csr_wdata
);

   localparam int ROW_AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_AW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ADDR_W  = ROW_AW + COL_AW;
   localparam int ENTRY_W = COST_BITS + 1;
   localparam int WW      = gpbt_pkg::WIDE_W;
   localparam int CW      = gpbt_pkg::COORD_W;
   localparam int SW      = gpbt_pkg::SCAN_W;

   // Configuration registers.
   logic [gpbt_pkg::CFG_W-1:0] grid_rows_ff, grid_rows_in;
   logic [gpbt_pkg::CFG_W-1:0] grid_cols_ff, grid_cols_in;

   // Controller state and outputs.
   gpbt_pkg::gpbt_state_type state_ff, state_in;
   logic rsp_free;
   logic req_take;
   logic step_take;
   logic write_take;
   logic scan_issue;
   logic load_done;

   // Query context.
   logic [CW-1:0] q_row_ff, q_row_in;
   logic [CW-1:0] q_col_ff, q_col_in;
   logic          oob_ff, oob_in;
   logic [SW-1:0] iss_k_ff, iss_k_in;

   // Read tracking for the returning memory word.
   logic          rd_pend_ff, rd_pend_in;
   logic          rd_live_ff, rd_live_in;
   logic [SW-1:0] rd_tag_ff, rd_tag_in;
   logic [CW-1:0] rd_row_ff, rd_row_in;
   logic [CW-1:0] rd_col_ff, rd_col_in;

   // Running search result.
   logic [COST_BITS-1:0] best_ff, best_in;
   logic                 found_ff, found_in;
   logic                 here_zero_ff, here_zero_in;
   logic [CW-1:0]        best_row_ff, best_row_in;
   logic [CW-1:0]        best_col_ff, best_col_in;

   // Result register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] rsp_row_ff, rsp_row_in;
   logic [CW-1:0] rsp_col_ff, rsp_col_in;
   logic          rsp_start_ff, rsp_start_in;
   logic          rsp_stuck_ff, rsp_stuck_in;

   // Bounds and neighbor address.
   logic [WW-1:0] row_bound;
   logic [WW-1:0] col_bound;
   logic [WW-1:0] req_row_w;
   logic [WW-1:0] req_col_w;
   logic          req_oob;
   logic          req_in_store;
   gpbt_pkg::gpbt_offset_type off;
   logic [WW-1:0] nbr_row;
   logic [WW-1:0] nbr_col;
   logic          nbr_live;

   // Memory ports.
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;
   logic [ADDR_W-1:0]  mem_raddr;
   logic [ENTRY_W-1:0] mem_rdata;
   logic [COST_BITS-1:0] rd_cost;
   logic               rd_blk;

   // Effective grid bounds: the configured size, capped by the storage size.
   always_comb begin
      row_bound = (WW'(grid_rows_ff) < WW'(MAX_ROWS)) ? WW'(grid_rows_ff) : WW'(MAX_ROWS);
      col_bound = (WW'(grid_cols_ff) < WW'(MAX_COLS)) ? WW'(grid_cols_ff) : WW'(MAX_COLS);
   end

   // Request decode.
   always_comb begin
      req_row_w    = WW'(req_cell_row);
      req_col_w    = WW'(req_cell_col);
      req_oob      = (req_row_w >= row_bound) || (req_col_w >= col_bound);
      req_in_store = (req_row_w < WW'(MAX_ROWS)) && (req_col_w < WW'(MAX_COLS));
      rsp_free     = !rsp_valid_ff || rsp_ready;
      req_take     = req_valid && req_ready;
      step_take    = req_take && (req_op == gpbt_pkg::OP_STEP);
      write_take   = req_take && (req_op == gpbt_pkg::OP_WRITE);
   end

   // Configuration writes.
   always_comb begin
      grid_rows_in = grid_rows_ff;
      grid_cols_in = grid_cols_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            gpbt_pkg::REG_GRID_ROWS: grid_rows_in = csr_wdata;
            gpbt_pkg::REG_GRID_COLS: grid_cols_in = csr_wdata;
         endcase
      end
   end

   // Controller next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gpbt_pkg::ST_IDLE: begin
            if (step_take) begin
               state_in = req_oob ? gpbt_pkg::ST_DONE : gpbt_pkg::ST_SCAN;
            end
         end
         gpbt_pkg::ST_SCAN: begin
            if (rd_pend_ff && (rd_tag_ff == gpbt_pkg::SCAN_LAST)) begin
               state_in = gpbt_pkg::ST_DONE;
            end
         end
         gpbt_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = gpbt_pkg::ST_IDLE;
            end
         end
         default: state_in = gpbt_pkg::ST_IDLE;
      endcase
   end

   // Controller outputs.
   always_comb begin
      req_ready  = 1'b0;
      scan_issue = 1'b0;
      load_done  = 1'b0;
      unique case (state_ff)
         gpbt_pkg::ST_IDLE: req_ready  = (req_op == gpbt_pkg::OP_STEP) || rsp_free;
         gpbt_pkg::ST_SCAN: scan_issue = (iss_k_ff <= gpbt_pkg::SCAN_LAST);
         gpbt_pkg::ST_DONE: load_done  = rsp_free;
         default: begin
            req_ready  = 1'b0;
            scan_issue = 1'b0;
            load_done  = 1'b0;
         end
      endcase
   end

   // Neighbor coordinate for the current scan slot and its bounds check.
   always_comb begin
      off     = gpbt_pkg::nbr_offset(iss_k_ff);
      nbr_row = WW'(q_row_ff);
      nbr_col = WW'(q_col_ff);
      if (off.row_inc) nbr_row = WW'(q_row_ff) + WW'(1);
      if (off.row_dec) nbr_row = WW'(q_row_ff) - WW'(1);
      if (off.col_inc) nbr_col = WW'(q_col_ff) + WW'(1);
      if (off.col_dec) nbr_col = WW'(q_col_ff) - WW'(1);
      nbr_live = !(off.row_dec && (q_row_ff == '0)) &&
                 !(off.col_dec && (q_col_ff == '0)) &&
                 (nbr_row < row_bound) && (nbr_col < col_bound);
   end

   // Memory access: writes only in idle, reads only while scanning.
   always_comb begin
      mem_we    = write_take && req_in_store;
      mem_waddr = {req_row_w[ROW_AW-1:0], req_col_w[COL_AW-1:0]};
      mem_wdata = {req_cell_blocked, COST_BITS'(req_cell_cost)};
      mem_raddr = {nbr_row[ROW_AW-1:0], nbr_col[COL_AW-1:0]};
      rd_cost   = mem_rdata[COST_BITS-1:0];
      rd_blk    = mem_rdata[COST_BITS];
   end

   gpbt_grid_ram #(
      .ADDR_W (ADDR_W),
      .DATA_W (ENTRY_W)
   ) u_grid_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (scan_issue),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Query context and read tracking.
   always_comb begin
      q_row_in   = q_row_ff;
      q_col_in   = q_col_ff;
      oob_in     = oob_ff;
      iss_k_in   = iss_k_ff;
      rd_pend_in = scan_issue;
      rd_live_in = nbr_live;
      rd_tag_in  = iss_k_ff;
      rd_row_in  = nbr_row[CW-1:0];
      rd_col_in  = nbr_col[CW-1:0];
      if (step_take) begin
         q_row_in = req_cell_row;
         q_col_in = req_cell_col;
         oob_in   = req_oob;
         iss_k_in = gpbt_pkg::SCAN_HERE;
      end else if (scan_issue) begin
         iss_k_in = iss_k_ff + SW'(1);
      end
   end

   // Search update as each memory word returns.
   always_comb begin
      best_in      = best_ff;
      found_in     = found_ff;
      here_zero_in = here_zero_ff;
      best_row_in  = best_row_ff;
      best_col_in  = best_col_ff;
      if (step_take) begin
         found_in     = 1'b0;
         here_zero_in = 1'b0;
      end else if (rd_pend_ff) begin
         if (rd_tag_ff == gpbt_pkg::SCAN_HERE) begin
            best_in      = rd_cost;
            here_zero_in = (rd_cost == '0);
         end else if (rd_live_ff && !rd_blk && (rd_cost < best_ff)) begin
            best_in     = rd_cost;
            found_in    = 1'b1;
            best_row_in = rd_row_ff;
            best_col_in = rd_col_ff;
         end
      end
   end

   // Result register: write acknowledgments and finished steps.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_start_in = rsp_start_ff;
      rsp_stuck_in = rsp_stuck_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (write_take) begin
         rsp_valid_in = 1'b1;
         rsp_row_in   = '0;
         rsp_col_in   = '0;
         rsp_start_in = 1'b0;
         rsp_stuck_in = 1'b0;
      end else if (load_done) begin
         rsp_valid_in = 1'b1;
         rsp_start_in = !oob_ff && here_zero_ff;
         rsp_stuck_in = oob_ff || (!here_zero_ff && !found_ff);
         rsp_row_in   = (!oob_ff && found_ff) ? best_row_ff : '0;
         rsp_col_in   = (!oob_ff && found_ff) ? best_col_ff : '0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= gpbt_pkg::CFG_W'(64);
         grid_cols_ff <= gpbt_pkg::CFG_W'(64);
         state_ff     <= gpbt_pkg::ST_IDLE;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         grid_rows_ff <= grid_rows_in;
         grid_cols_ff <= grid_cols_in;
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      q_row_ff     <= q_row_in;
      q_col_ff     <= q_col_in;
      oob_ff       <= oob_in;
      iss_k_ff     <= iss_k_in;
      rd_live_ff   <= rd_live_in;
      rd_tag_ff    <= rd_tag_in;
      rd_row_ff    <= rd_row_in;
      rd_col_ff    <= rd_col_in;
      best_ff      <= best_in;
      found_ff     <= found_in;
      here_zero_ff <= here_zero_in;
      best_row_ff  <= best_row_in;
      best_col_ff  <= best_col_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_start_ff <= rsp_start_in;
      rsp_stuck_ff <= rsp_stuck_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_next_row = rsp_row_ff;
   assign rsp_next_col = rsp_col_ff;
   assign rsp_at_start = rsp_start_ff;
   assign rsp_stuck    = rsp_stuck_ff;

`ifndef SYNTHESIS
   // The grid is never written while a scan reads it.
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gpbt_pkg::ST_SCAN) |-> !mem_we)
      else $error("grid write during a scan");

   // A returning word always belongs to the slot issued just before.
   a_tag_follows_issue: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> ((rd_tag_ff + SW'(1)) == iss_k_ff))
      else $error("read tag out of step with issue counter");

   // An accepted step leaves idle.
   a_step_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      step_take |=> (state_ff != gpbt_pkg::ST_IDLE))
      else $error("step item accepted without starting");

   // Start and stuck never come together, and both carry no neighbor.
   a_result_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_start_ff || rsp_stuck_ff)) |->
      (!(rsp_start_ff && rsp_stuck_ff) && (rsp_row_ff == '0) && (rsp_col_ff == '0)))
      else $error("inconsistent result flags");
`endif

endmodule
